// ===== sv/crs_pkg.sv =====
// shared types and codes for the clip rectangle stack
package crs_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int DEPTH_W = 4;

	localparam logic [1:0] OP_INIT = 2'd0;
	localparam logic [1:0] OP_PUSH = 2'd1;
	localparam logic [1:0] OP_POP  = 2'd2;

	typedef struct packed {
		logic [14:0]        h;
		logic [14:0]        w;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} rect_t;

	// per-cell load controls
	typedef struct packed {
		logic take_up;
		logic take_dn;
	} cell_ctl_t;

endpackage

// ===== sv/crs_cell.sv =====
// one stack cell: holds an entry, loads from the neighbor above or below
module crs_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  crs_pkg::cell_ctl_t ctl,
	input  crs_pkg::rect_t     from_up,
	input  crs_pkg::rect_t     from_dn,
	output crs_pkg::rect_t     ent
);
	import crs_pkg::*;

	rect_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (ctl.take_up) begin
			ent_q <= from_up;
		end else if (ctl.take_dn) begin
			ent_q <= from_dn;
		end
	end

	assign ent = ent_q;

endmodule

// ===== sv/crs_isect.sv =====
// intersection of a pushed rectangle with the top entry, sizes clamped at zero
module crs_isect (
	input  crs_pkg::rect_t rect,
	input  crs_pkg::rect_t top,
	output crs_pkg::rect_t res
);
	import crs_pkg::*;

	logic signed [16:0] r_x1, r_y1, t_x1, t_y1, min_x1, min_y1;
	logic signed [15:0] x0, y0;
	logic signed [17:0] nw, nh;

	always_comb begin
		r_x1 = {rect.x[15], rect.x} + $signed({2'b00, rect.w});
		r_y1 = {rect.y[15], rect.y} + $signed({2'b00, rect.h});
		t_x1 = {top.x[15], top.x} + $signed({2'b00, top.w});
		t_y1 = {top.y[15], top.y} + $signed({2'b00, top.h});
		x0 = (rect.x > top.x) ? rect.x : top.x;
		y0 = (rect.y > top.y) ? rect.y : top.y;
		min_x1 = (r_x1 < t_x1) ? r_x1 : t_x1;
		min_y1 = (r_y1 < t_y1) ? r_y1 : t_y1;
		nw = {min_x1[16], min_x1} - {{2{x0[15]}}, x0};
		nh = {min_y1[16], min_y1} - {{2{y0[15]}}, y0};
		res.x = x0;
		res.y = y0;
		res.w = nw[17] ? 15'd0 : nw[14:0];
		res.h = nh[17] ? 15'd0 : nh[14:0];
	end

endmodule

// ===== sv/clip_rect_stack_unit.sv =====
// clip rectangle stack: a row of shifting cells, top entry in cell zero
//
//  channel | signals                    | payload
//  --------+----------------------------+------------------------------------
//  in      | s_tvalid s_tready          | tdata x y w h, tuser op
//  out     | m_tvalid m_tready          | tdata clip x y w h depth, tuser status
//
// one request per cycle while the output is not stalled; the result is registered, in the cycle after acceptance
// push shifts every cell down one place, pop shifts every cell up one place
// reset clears all cells, the depth and the output register
// s_tready is low only while a result waits and m_tready is low
module clip_rect_stack_unit #(
	parameter int STACK_DEPTH = crs_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // rect_x[15:0] rect_y[31:16] rect_w[46:32] rect_h[61:47]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // clip_x[15:0] clip_y[31:16] clip_w[46:32] clip_h[61:47]
	                               // depth[65:62]
	output logic [0:0]  m_tuser    // status[0]
);
	import crs_pkg::*;

	localparam int IW = $clog2(STACK_DEPTH);

	rect_t     ent [STACK_DEPTH];
	cell_ctl_t ctl [STACK_DEPTH];
	rect_t     in_rect, isect_res, head, nxt_rect;
	logic [IW-1:0] top_q, top_nxt;
	logic [IW+3:0] depth_ext;
	logic      accept, full, at_base, do_push, do_pop, do_init, ignored;
	logic      out_vld_q, status_q;
	rect_t     clip_q;
	logic [DEPTH_W-1:0] depth_q;

	assign in_rect = s_tdata[61:0];
	assign accept  = s_tvalid && s_tready;
	assign s_tready = !out_vld_q || m_tready;

	assign full    = (top_q == IW'(STACK_DEPTH - 1));
	assign at_base = (top_q == '0);
	assign do_init = (s_tuser == OP_INIT);
	assign do_push = (s_tuser == OP_PUSH) && !full;
	assign do_pop  = (s_tuser == OP_POP) && !at_base;
	assign ignored = !(do_init || do_push || do_pop);

	crs_isect u_isect (
		.rect (in_rect),
		.top  (ent[0]),
		.res  (isect_res)
	);

	assign head = do_init ? in_rect : isect_res;

	genvar k;
	generate
		for (k = 0; k < STACK_DEPTH; k++) begin : g_cell
			rect_t up_w, dn_w;
			if (k == 0) begin : g_head
				assign up_w = head;
			end else begin : g_mid
				assign up_w = ent[k-1];
			end
			if (k == STACK_DEPTH - 1) begin : g_tail
				assign dn_w = '0;
			end else begin : g_body
				assign dn_w = ent[k+1];
			end
			assign ctl[k].take_up = accept && (do_push || (do_init && k == 0));
			assign ctl[k].take_dn = accept && do_pop;

			crs_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl[k]),
				.from_up (up_w),
				.from_dn (dn_w),
				.ent     (ent[k])
			);
		end
	endgenerate

	always_comb begin
		top_nxt  = top_q;
		nxt_rect = ent[0];
		if (do_init) begin
			top_nxt  = '0;
			nxt_rect = in_rect;
		end else if (do_push) begin
			top_nxt  = top_q + 1'b1;
			nxt_rect = isect_res;
		end else if (do_pop) begin
			top_nxt  = top_q - 1'b1;
			nxt_rect = ent[1];
		end
	end

	assign depth_ext = {4'b0000, top_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				top_q     <= top_nxt;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q   <= '0;
			depth_q  <= '0;
			status_q <= 1'b0;
		end else if (accept) begin
			clip_q   <= nxt_rect;
			depth_q  <= depth_ext[3:0];
			status_q <= ignored;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'b000000, depth_q, clip_q};
	assign m_tuser  = status_q;

endmodule
